@@ sv/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg - shared types and constants for pressure/temperature compensation
// Calibration register block, register index codes and the word that the
// front stages hand to the back stages through the queue.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Register index codes of the calibration port.
    localparam int CAL_IDX_W = 3;
    localparam logic [CAL_IDX_W-1:0] REG_PRESSURE_SENS   = 3'd0;
    localparam logic [CAL_IDX_W-1:0] REG_PRESSURE_OFFSET = 3'd1;
    localparam logic [CAL_IDX_W-1:0] REG_SENS_TEMP_COEF  = 3'd2;
    localparam logic [CAL_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
    localparam logic [CAL_IDX_W-1:0] REG_REF_TEMPERATURE = 3'd4;
    localparam logic [CAL_IDX_W-1:0] REG_TEMPERATURE_COEF = 3'd5;

    // Reference temperature of the first-order law, in hundredths of a degree.
    localparam logic signed [18:0] TEMP_REF_CENTI = 19'sd2000;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [15:0] pressure_sensitivity;
        logic [15:0] pressure_offset;
        logic [15:0] sensitivity_temp_coef;
        logic [15:0] offset_temp_coef;
        logic [15:0] reference_temperature;
        logic [15:0] temperature_coef;
    } ptc_cal_t;

    // First-order results plus what the low-temperature correction needs.
    typedef struct packed {
        logic [23:0]        d1;
        logic               low;
        logic signed [18:0] temp1;
        logic [16:0]        ti;
        logic signed [37:0] off1;
        logic signed [36:0] sens1;
        logic [34:0]        sq;
    } ptc_word_t;

endpackage

@@ sv/pressure_temperature_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation - barometric sensor compensation
// Turns a raw pressure and temperature conversion pair into a compensated
// temperature (0.01 degC) and pressure (0.01 mbar) with second-order
// low-temperature correction, using six calibration words.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Word
//  s_        in         s_valid / s_ready      s_pressure_raw, s_temperature_raw
//  m_        out        m_valid / m_ready      m_temperature_centideg,
//                                              m_pressure_centimbar
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One word is accepted every clock cycle while s_ready is high: every stage
//  is a pipeline register and nothing is carried from one word to the next.
//  With no back-pressure m_valid rises once a word has passed every stage.
//  Reset clears all calibration words to zero and empties every stage.
//  When m_ready is low the back stages fill first, then the queue, then the
//  front, and only then s_ready falls; the front works while the back waits.
//
module pressure_temperature_compensation import ptc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [23:0]          s_pressure_raw,
    input  logic [23:0]          s_temperature_raw,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [18:0]   m_temperature_centideg,
    output logic signed [31:0]   m_pressure_centimbar,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAL_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    ptc_cal_t  cal_reg, cal_next;
    ptc_word_t front_word, queue_word;
    logic      front_vld, queue_in_rdy, queue_out_vld, back_in_rdy;

    // Calibration words. The port never stalls; writes to an index beyond
    // the last register are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PRESSURE_SENS:    cal_next.pressure_sensitivity  = cfg_data;
                REG_PRESSURE_OFFSET:  cal_next.pressure_offset       = cfg_data;
                REG_SENS_TEMP_COEF:   cal_next.sensitivity_temp_coef = cfg_data;
                REG_OFFSET_TEMP_COEF: cal_next.offset_temp_coef      = cfg_data;
                REG_REF_TEMPERATURE:  cal_next.reference_temperature = cfg_data;
                REG_TEMPERATURE_COEF: cal_next.temperature_coef      = cfg_data;
                default: begin
                    cal_next = cal_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    // Front: first-order terms and the low-temperature decision.
    ptc_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cal                (cal_reg),
        .in_valid           (s_valid),
        .in_ready           (s_ready),
        .in_pressure_raw    (s_pressure_raw),
        .in_temperature_raw (s_temperature_raw),
        .out_valid          (front_vld),
        .out_ready          (queue_in_rdy),
        .out_word           (front_word)
    );

    // Queue so that a stalled result side does not stop the front at once.
    ptc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_vld),
        .in_ready  (queue_in_rdy),
        .in_word   (front_word),
        .out_valid (queue_out_vld),
        .out_ready (back_in_rdy),
        .out_word  (queue_word)
    );

    // Back: correction, pressure product and the result register.
    ptc_back u_back (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .in_valid                 (queue_out_vld),
        .in_ready                 (back_in_rdy),
        .in_word                  (queue_word),
        .out_valid                (m_valid),
        .out_ready                (m_ready),
        .out_temperature_centideg (m_temperature_centideg),
        .out_pressure_centimbar   (m_pressure_centimbar)
    );

    // The input side may only stall once the queue is full.
    a_stall_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> !queue_in_rdy)
        else $error("input stalled while the queue had room");

    // With the result taken every cycle the back never blocks the queue.
    a_back_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> back_in_rdy)
        else $error("back stages stalled although the result side was ready");

    // A word leaving a full queue frees a place on the next cycle.
    a_queue_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (queue_out_vld && back_in_rdy && !queue_in_rdy) |=> queue_in_rdy)
        else $error("queue stayed full after a word was taken");

endmodule

@@ sv/ptc_front.sv @@
// ----------------------------------------------------------------------------
// ptc_front - first-order compensation stages
// Two elastic stages: the temperature difference products, then the
// first-order temperature, offset and sensitivity and the low-temperature
// classification.
// ----------------------------------------------------------------------------
module ptc_front import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ptc_cal_t    cal,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] in_pressure_raw,
    input  logic [23:0] in_temperature_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output ptc_word_t   out_word
);

    typedef struct packed {
        logic [23:0]        d1;
        logic signed [41:0] pt;
        logic signed [41:0] po;
        logic signed [41:0] ps;
        logic [47:0]        dt2;
    } ptc_prod_t;

    ptc_prod_t s1_reg, s1_next;
    ptc_word_t w_reg, w_next;
    logic      v1_reg, v2_reg;
    logic      rdy1, rdy2;

    logic signed [24:0] dt_c;
    logic signed [49:0] dt2_c;
    logic signed [18:0] pt_sh;
    logic signed [35:0] po_sh;
    logic signed [34:0] ps_sh;
    logic signed [37:0] sq_c;
    logic [51:0]        t11_c;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: difference to the reference temperature and its products.
    assign dt_c  = $signed({1'b0, in_temperature_raw})
                 - $signed({1'b0, cal.reference_temperature, 8'd0});
    assign dt2_c = dt_c * dt_c;

    always_comb begin
        s1_next.d1  = in_pressure_raw;
        s1_next.pt  = dt_c * $signed({1'b0, cal.temperature_coef});
        s1_next.po  = dt_c * $signed({1'b0, cal.offset_temp_coef});
        s1_next.ps  = dt_c * $signed({1'b0, cal.sensitivity_temp_coef});
        s1_next.dt2 = dt2_c[47:0];
    end

    // Stage 2: floor shifts are taken as part-selects of the products.
    assign pt_sh = $signed(s1_reg.pt[41:23]);
    assign po_sh = $signed(s1_reg.po[41:6]);
    assign ps_sh = $signed(s1_reg.ps[41:7]);
    assign sq_c  = pt_sh * pt_sh;
    assign t11_c = (52'(s1_reg.dt2) << 3) + (52'(s1_reg.dt2) << 1) + 52'(s1_reg.dt2);

    always_comb begin
        w_next.d1    = s1_reg.d1;
        // The first-order temperature is below the reference exactly when
        // the temperature product is negative.
        w_next.low   = s1_reg.pt[41];
        w_next.temp1 = pt_sh + TEMP_REF_CENTI;
        w_next.ti    = t11_c[51:35];
        w_next.off1  = $signed({5'd0, cal.pressure_offset, 17'd0}) + po_sh;
        w_next.sens1 = $signed({5'd0, cal.pressure_sensitivity, 16'd0}) + ps_sh;
        w_next.sq    = sq_c[34:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            w_reg <= w_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_word  = w_reg;

endmodule

@@ sv/ptc_fifo.sv @@
// ----------------------------------------------------------------------------
// ptc_fifo - short queue between the front and back stages
// Register-based first-in first-out store of compensation words.
// ----------------------------------------------------------------------------
module ptc_fifo import ptc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ptc_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output ptc_word_t out_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptc_word_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_word  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

@@ sv/ptc_back.sv @@
// ----------------------------------------------------------------------------
// ptc_back - low-temperature correction and pressure stages
// Five elastic stages: correction terms, their application, the split
// pressure product, its recombination and the final offset and shift, which
// is also the result register.
// ----------------------------------------------------------------------------
module ptc_back import ptc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptc_word_t          in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [18:0] out_temperature_centideg,
    output logic signed [31:0] out_pressure_centimbar
);

    typedef struct packed {
        logic [23:0]        d1;
        logic               low;
        logic signed [18:0] temp1;
        logic [16:0]        ti;
        logic signed [37:0] off1;
        logic signed [36:0] sens1;
        logic [36:0]        offi;
        logic [35:0]        sensi;
    } ptc_corr_t;

    typedef struct packed {
        logic [23:0]        d1;
        logic signed [18:0] temp;
        logic signed [38:0] off;
        logic signed [37:0] sens;
    } ptc_comp_t;

    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [38:0] off;
        logic [41:0]        plo;
        logic signed [44:0] phi;
    } ptc_mul_t;

    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [38:0] off;
        logic signed [41:0] xs;
    } ptc_sum_t;

    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [31:0] p;
    } ptc_res_t;

    ptc_corr_t a_reg, a_next;
    ptc_comp_t b_reg, b_next;
    ptc_mul_t  c_reg, c_next;
    ptc_sum_t  d_reg, d_next;
    ptc_res_t  e_reg, e_next;
    logic      va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic      rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    logic [39:0]        sq31_c;
    logic [40:0]        sq63_c;
    logic signed [62:0] x_c;
    logic signed [42:0] y_c;

    assign rdy_e    = !ve_reg || out_ready;
    assign rdy_d    = !vd_reg || rdy_e;
    assign rdy_c    = !vc_reg || rdy_d;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // Stage A: 31 and 63 times the squared temperature deviation.
    assign sq31_c = {in_word.sq, 5'd0} - {5'd0, in_word.sq};
    assign sq63_c = {in_word.sq, 6'd0} - {6'd0, in_word.sq};

    always_comb begin
        a_next.d1    = in_word.d1;
        a_next.low   = in_word.low;
        a_next.temp1 = in_word.temp1;
        a_next.ti    = in_word.ti;
        a_next.off1  = in_word.off1;
        a_next.sens1 = in_word.sens1;
        a_next.offi  = sq31_c[39:3];
        a_next.sensi = sq63_c[40:5];
    end

    // Stage B: apply the correction below the reference temperature.
    always_comb begin
        b_next.d1 = a_reg.d1;
        if (a_reg.low) begin
            b_next.temp = $signed(a_reg.temp1) - $signed({2'b00, a_reg.ti});
            b_next.off  = $signed({a_reg.off1[37], a_reg.off1})
                        - $signed({2'b00, a_reg.offi});
            b_next.sens = $signed({a_reg.sens1[36], a_reg.sens1})
                        - $signed({2'b00, a_reg.sensi});
        end else begin
            b_next.temp = a_reg.temp1;
            b_next.off  = $signed({a_reg.off1[37], a_reg.off1});
            b_next.sens = $signed({a_reg.sens1[36], a_reg.sens1});
        end
    end

    // Stage C: raw pressure times sensitivity, split at bit 18.
    always_comb begin
        c_next.temp = b_reg.temp;
        c_next.off  = b_reg.off;
        c_next.plo  = 42'(b_reg.d1) * 42'(b_reg.sens[17:0]);
        c_next.phi  = $signed({1'b0, b_reg.d1}) * $signed(b_reg.sens[37:18]);
    end

    // Stage D: recombine the partial products and drop 21 bits.
    assign x_c = $signed({c_reg.phi, 18'd0}) + $signed({21'd0, c_reg.plo});

    always_comb begin
        d_next.temp = c_reg.temp;
        d_next.off  = c_reg.off;
        d_next.xs   = $signed(x_c[62:21]);
    end

    // Stage E: subtract the offset and drop 15 bits; the value fits 28 bits.
    assign y_c = $signed({d_reg.xs[41], d_reg.xs}) - $signed({{4{d_reg.off[38]}}, d_reg.off});

    always_comb begin
        e_next.temp = d_reg.temp;
        e_next.p    = $signed({{4{y_c[42]}}, y_c[42:15]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
            if (rdy_c) begin
                vc_reg <= vb_reg;
            end
            if (rdy_d) begin
                vd_reg <= vc_reg;
            end
            if (rdy_e) begin
                ve_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            a_reg <= a_next;
        end
        if (rdy_b) begin
            b_reg <= b_next;
        end
        if (rdy_c) begin
            c_reg <= c_next;
        end
        if (rdy_d) begin
            d_reg <= d_next;
        end
        if (rdy_e) begin
            e_reg <= e_next;
        end
    end

    assign out_valid                = ve_reg;
    assign out_temperature_centideg = e_reg.temp;
    assign out_pressure_centimbar   = e_reg.p;

endmodule
